@@ hdl/rau_pkg.sv @@
package rau_pkg;

	typedef logic [3:0] action_t;

	localparam action_t ACT_ADD = 4'd0;
	localparam action_t ACT_SUB = 4'd1;
	localparam action_t ACT_MUL = 4'd2;
	localparam action_t ACT_DIV = 4'd3;
	localparam action_t ACT_EQ  = 4'd4;
	localparam action_t ACT_NE  = 4'd5;
	localparam action_t ACT_LT  = 4'd6;
	localparam action_t ACT_GT  = 4'd7;
	localparam action_t ACT_LE  = 4'd8;
	localparam action_t ACT_GE  = 4'd9;

	localparam int RES_NUM_W = 33;
	localparam int RES_DEN_W = 31;

endpackage

@@ hdl/rational_arithmetic_unit_core.sv @@
// channel | signals                                              | direction
// input   | in_valid, in_stall, action, first/second num and den | into block
// output  | out_valid, out_stall, result_*, compare_true,        | out of block
//         | divide_by_zero                                       |
//
// One item at a time: in_stall is high from acceptance until the result beat
// is taken. An item passes through the shared multiplier in states M0, M1 and
// M2, a set-up state PREP, then the shared bit-serial divider for each Euclid
// remainder step, a check for the gcd, and the two divisions (NDIV, DDIV)
// that take the gcd out.
// Comparisons, zero results and division by zero skip the divider.
// arst_n clears the sequencer; out_valid holds with its beat until out_stall
// is low.
module rational_arithmetic_unit_core
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [3:0]                           action,
	input  logic signed [OPERAND_WIDTH-1:0]      first_numerator,
	input  logic [OPERAND_WIDTH-2:0]             first_denominator,
	input  logic signed [OPERAND_WIDTH-1:0]      second_numerator,
	input  logic [OPERAND_WIDTH-2:0]             second_denominator,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [RES_NUM_W-1:0]          result_numerator,
	output logic [RES_DEN_W-1:0]                 result_denominator,
	output logic                                 compare_true,
	output logic                                 divide_by_zero
);

	localparam int W  = OPERAND_WIDTH;
	localparam int MW = 2 * W;
	localparam int CW = $clog2(MW + 1);
	localparam int XW = 65;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_M0   = 4'd1;
	localparam logic [3:0] ST_M1   = 4'd2;
	localparam logic [3:0] ST_M2   = 4'd3;
	localparam logic [3:0] ST_PREP = 4'd4;
	localparam logic [3:0] ST_GCD  = 4'd5;
	localparam logic [3:0] ST_NDIV = 4'd6;
	localparam logic [3:0] ST_DDIV = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0]              state_q;
	action_t                 act_q;
	logic signed [W:0]       n1_q, d1_q, n2_q, d2_q;
	logic signed [MW:0]      left_q, right_q, den_q;
	logic [MW-1:0]           a_q, b_q, mn_q, md_q;
	logic                    neg_q, ld_q;
	logic [MW-1:0]           rem_q, quo_q, dv_q;
	logic [CW-1:0]           cnt_q;
	logic signed [RES_NUM_W-1:0] res_num_q;
	logic [RES_DEN_W-1:0]    res_den_q;
	logic                    cmp_q, dz_q;

	// shared multiplier
	logic signed [W:0]       mx, my;
	logic signed [2*W+1:0]   prod;

	always_comb begin
		mx = n1_q;
		my = d2_q;
		case (state_q)
			ST_M0: begin
				mx = n1_q;
				my = (act_q == ACT_MUL) ? n2_q : d2_q;
			end
			ST_M1: begin
				mx = n2_q;
				my = d1_q;
			end
			ST_M2: begin
				mx = d1_q;
				my = (act_q == ACT_DIV) ? n2_q : d2_q;
			end
			default: begin
				mx = n1_q;
				my = d2_q;
			end
		endcase
	end

	assign prod = mx * my;

	// numerator and magnitudes for reduction
	logic signed [MW:0] num_c, num_abs, den_abs;
	logic               cmp_c;

	always_comb begin
		case (act_q)
			ACT_ADD: num_c = left_q + right_q;
			ACT_SUB: num_c = left_q - right_q;
			default: num_c = left_q;
		endcase
		num_abs = num_c[MW] ? -num_c : num_c;
		den_abs = den_q[MW] ? -den_q : den_q;
		case (act_q)
			ACT_EQ:  cmp_c = (left_q == right_q);
			ACT_NE:  cmp_c = (left_q != right_q);
			ACT_LT:  cmp_c = (left_q <  right_q);
			ACT_GT:  cmp_c = (left_q >  right_q);
			ACT_LE:  cmp_c = (left_q <= right_q);
			ACT_GE:  cmp_c = (left_q >= right_q);
			default: cmp_c = 1'b0;
		endcase
	end

	// bit-serial restoring divider step
	logic [MW:0]   sh, diff;
	always_comb begin
		sh   = {rem_q, quo_q[MW-1]};
		diff = sh - {1'b0, dv_q};
	end

	// final result, widened then cut to the field widths
	logic [XW-1:0] mag_x, num_x, den_x;
	always_comb begin
		mag_x = {{(XW-MW){1'b0}}, mn_q};
		num_x = neg_q ? (~mag_x + XW'(1)) : mag_x;
		den_x = {{(XW-MW){1'b0}}, quo_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ld_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						n1_q    <= {first_numerator[W-1], first_numerator};
						n2_q    <= {second_numerator[W-1], second_numerator};
						d1_q    <= (first_denominator == '0) ? (W+1)'(1)
						           : {2'b00, first_denominator};
						d2_q    <= (second_denominator == '0) ? (W+1)'(1)
						           : {2'b00, second_denominator};
						state_q <= ST_M0;
					end
				end
				ST_M0: begin
					left_q  <= prod[MW:0];
					state_q <= ST_M1;
				end
				ST_M1: begin
					right_q <= prod[MW:0];
					state_q <= ST_M2;
				end
				ST_M2: begin
					den_q   <= prod[MW:0];
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					res_num_q <= '0;
					res_den_q <= RES_DEN_W'(1);
					cmp_q     <= cmp_c;
					dz_q      <= (act_q == ACT_DIV) && (n2_q == '0);
					a_q       <= num_abs[MW-1:0];
					b_q       <= den_abs[MW-1:0];
					mn_q      <= num_abs[MW-1:0];
					md_q      <= den_abs[MW-1:0];
					neg_q     <= num_c[MW] ^ den_q[MW];
					ld_q      <= 1'b1;
					if (act_q > ACT_DIV || (act_q == ACT_DIV && n2_q == '0)
					    || num_c == '0)
						state_q <= ST_OUT;
					else
						state_q <= ST_GCD;
				end
				ST_GCD: begin
					if (ld_q) begin
						rem_q <= '0;
						cnt_q <= CW'(MW);
						ld_q  <= 1'b0;
						if (b_q == '0) begin
							// gcd found: divide it out of the numerator
							quo_q   <= mn_q;
							dv_q    <= a_q;
							state_q <= ST_NDIV;
						end else begin
							quo_q <= a_q;
							dv_q  <= b_q;
						end
					end else if (cnt_q != '0) begin
						rem_q <= diff[MW] ? sh[MW-1:0] : diff[MW-1:0];
						quo_q <= {quo_q[MW-2:0], ~diff[MW]};
						cnt_q <= cnt_q - CW'(1);
					end else begin
						a_q  <= b_q;
						b_q  <= rem_q;
						ld_q <= 1'b1;
					end
				end
				ST_NDIV: begin
					if (cnt_q != '0) begin
						rem_q <= diff[MW] ? sh[MW-1:0] : diff[MW-1:0];
						quo_q <= {quo_q[MW-2:0], ~diff[MW]};
						cnt_q <= cnt_q - CW'(1);
					end else begin
						mn_q    <= quo_q;
						quo_q   <= md_q;
						rem_q   <= '0;
						cnt_q   <= CW'(MW);
						state_q <= ST_DDIV;
					end
				end
				ST_DDIV: begin
					if (cnt_q != '0) begin
						rem_q <= diff[MW] ? sh[MW-1:0] : diff[MW-1:0];
						quo_q <= {quo_q[MW-2:0], ~diff[MW]};
						cnt_q <= cnt_q - CW'(1);
					end else begin
						res_num_q <= num_x[RES_NUM_W-1:0];
						res_den_q <= den_x[RES_DEN_W-1:0];
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold the beat until taken
					if (!out_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall           = (state_q != ST_IDLE);
	assign out_valid          = (state_q == ST_OUT);
	assign result_numerator   = res_num_q;
	assign result_denominator = res_den_q;
	assign compare_true       = cmp_q;
	assign divide_by_zero     = dz_q;

endmodule
